// ===== rtl/qesg_pkg.sv =====
package qesg_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int DELAY_W         = 16;
    localparam int SPD_W           = 4;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 8;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_KEY_TWIST = 2'd1,
        CMD_KEY_PUSH  = 2'd2,
        CMD_MOUSE     = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_KEY_START_DELAY   = 3'd0;
    localparam logic [2:0] REG_WHEEL_START_DELAY = 3'd1;
    localparam logic [2:0] REG_STEP_INTERVAL     = 3'd2;
    localparam logic [2:0] REG_RELEASE_DELAY     = 3'd3;
    localparam logic [2:0] REG_STEPS_PER_DETENT  = 3'd4;

    localparam logic [DELAY_W-1:0] KEY_START_DELAY_RST   = 16'd100;
    localparam logic [DELAY_W-1:0] WHEEL_START_DELAY_RST = 16'd10;
    localparam logic [DELAY_W-1:0] STEP_INTERVAL_RST     = 16'd10;
    localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST     = 16'd100;
    localparam logic [SPD_W-1:0]   STEPS_PER_DETENT_RST  = 4'd2;

    typedef struct packed {
        logic [DELAY_W-1:0] key_start_delay;
        logic [DELAY_W-1:0] wheel_start_delay;
        logic [DELAY_W-1:0] step_interval;
        logic [DELAY_W-1:0] release_delay;
        logic [SPD_W-1:0]   steps_per_detent;
    } cfg_t;

    typedef struct packed {
        logic button_n;
        logic phase_b;
        logic phase_a;
    } lines_t;

    // a delay of zero behaves as one tick
    function automatic logic [DELAY_W-1:0] load_delay(input logic [DELAY_W-1:0] d);
        load_delay = (d == '0) ? DELAY_W'(1) : d;
    endfunction

    // phase table A1B1, A0B1, A0B0, A1B0
    function automatic logic phase_a_of(input logic [1:0] ph);
        phase_a_of = (ph == 2'd0) || (ph == 2'd3);
    endfunction

    function automatic logic phase_b_of(input logic [1:0] ph);
        phase_b_of = (ph == 2'd0) || (ph == 2'd1);
    endfunction

endpackage

// ===== rtl/qesg_engine.sv =====
module qesg_engine #(
    parameter int COUNT_WIDTH = qesg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  qesg_pkg::cmd_t       cmd,
    input  logic [1:0]           direction,
    input  logic                 pressed,
    input  qesg_pkg::cfg_t       cfg,
    output qesg_pkg::lines_t     lines_next
);

    logic [1:0]                      phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]          pending_reg, pending_next;
    logic [1:0]                      last_dir_reg, last_dir_next;
    logic [qesg_pkg::DELAY_W-1:0]    step_cnt_reg, step_cnt_next;
    logic                            step_armed_reg, step_armed_next;
    logic [qesg_pkg::DELAY_W-1:0]    rel_cnt_reg, rel_cnt_next;
    logic                            rel_armed_reg, rel_armed_next;
    logic                            mouse_reg, mouse_next;
    qesg_pkg::lines_t                lines_reg;

    logic [qesg_pkg::DELAY_W-1:0]    step_dec;
    logic [qesg_pkg::DELAY_W-1:0]    rel_dec;
    logic [1:0]                      phase_adv;
    logic [COUNT_WIDTH-1:0]          pend_dec;
    logic                            dir_nz;
    logic                            dir_change;
    logic [COUNT_WIDTH-1:0]          twist_base;
    logic [COUNT_WIDTH:0]            twist_sum;
    logic [COUNT_WIDTH-1:0]          twist_sat;

    assign step_dec   = (step_cnt_reg != '0) ? step_cnt_reg - 1'b1 : step_cnt_reg;
    assign rel_dec    = (rel_cnt_reg != '0) ? rel_cnt_reg - 1'b1 : rel_cnt_reg;
    assign phase_adv  = phase_reg + (last_dir_reg[1] ? 2'd1 : 2'd3);
    assign pend_dec   = (pending_reg != '0) ? pending_reg - 1'b1 : pending_reg;
    assign dir_nz     = |direction;
    assign dir_change = (direction != last_dir_reg);
    assign twist_base = dir_change ? '0 : pending_reg;
    assign twist_sum  = {1'b0, twist_base}
                      + {{(COUNT_WIDTH + 1 - qesg_pkg::SPD_W){1'b0}}, cfg.steps_per_detent};
    assign twist_sat  = twist_sum[COUNT_WIDTH] ? '1 : twist_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        last_dir_next   = last_dir_reg;
        step_cnt_next   = step_cnt_reg;
        step_armed_next = step_armed_reg;
        rel_cnt_next    = rel_cnt_reg;
        rel_armed_next  = rel_armed_reg;
        mouse_next      = mouse_reg;
        lines_next      = lines_reg;
        case (cmd)
            qesg_pkg::CMD_TICK:
            begin
                if (step_armed_reg)
                begin
                    step_cnt_next = step_dec;
                    if (step_dec == '0)
                    begin
                        phase_next         = phase_adv;
                        lines_next.phase_a = qesg_pkg::phase_a_of(phase_adv);
                        lines_next.phase_b = qesg_pkg::phase_b_of(phase_adv);
                        pending_next       = pend_dec;
                        if (pend_dec != '0)
                        begin
                            step_cnt_next   = qesg_pkg::load_delay(cfg.step_interval);
                            step_armed_next = 1'b1;
                        end
                        else
                        begin
                            step_armed_next = 1'b0;
                        end
                    end
                end
                if (rel_armed_reg)
                begin
                    rel_cnt_next = rel_dec;
                    if (rel_dec == '0)
                    begin
                        rel_armed_next      = 1'b0;
                        lines_next.button_n = 1'b1;
                    end
                end
            end
            qesg_pkg::CMD_KEY_TWIST:
            begin
                if (dir_nz)
                begin
                    last_dir_next   = direction;
                    pending_next    = twist_sat;
                    step_cnt_next   = qesg_pkg::load_delay(cfg.key_start_delay);
                    step_armed_next = 1'b1;
                end
            end
            qesg_pkg::CMD_KEY_PUSH:
            begin
                lines_next.button_n = 1'b0;
                rel_cnt_next        = qesg_pkg::load_delay(cfg.release_delay);
                rel_armed_next      = 1'b1;
            end
            qesg_pkg::CMD_MOUSE:
            begin
                if (pressed != mouse_reg)
                begin
                    lines_next.button_n = ~pressed;
                    mouse_next          = pressed;
                end
                if (dir_nz)
                begin
                    last_dir_next   = direction;
                    pending_next    = twist_sat;
                    step_cnt_next   = qesg_pkg::load_delay(cfg.wheel_start_delay);
                    step_armed_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= 2'd0;
            pending_reg        <= '0;
            last_dir_reg       <= 2'd0;
            step_cnt_reg       <= '0;
            step_armed_reg     <= 1'b0;
            rel_cnt_reg        <= '0;
            rel_armed_reg      <= 1'b0;
            mouse_reg          <= 1'b0;
            lines_reg.phase_a  <= 1'b0;
            lines_reg.phase_b  <= 1'b0;
            lines_reg.button_n <= 1'b1;
        end
        else if (en)
        begin
            phase_reg      <= phase_next;
            pending_reg    <= pending_next;
            last_dir_reg   <= last_dir_next;
            step_cnt_reg   <= step_cnt_next;
            step_armed_reg <= step_armed_next;
            rel_cnt_reg    <= rel_cnt_next;
            rel_armed_reg  <= rel_armed_next;
            mouse_reg      <= mouse_next;
            lines_reg      <= lines_next;
        end
    end

endmodule

// ===== rtl/quadrature_encoder_signal_generator_core.sv =====
// Quadrature encoder signal generator.
// Input stream (s_*): one item per millisecond tick, key twist, key push or
// mouse event; s_tuser carries the command, s_tdata the direction and the
// mouse button level. Every input item yields exactly one output item on
// m_* holding the A/B quadrature levels and the active-low button level as
// they stand after that item.
// The output item is registered and is valid the cycle after the input is accepted.
// Throughput: one item per clock while the receiver takes each output; the state
// update is combinational logic into the state registers and the output register.
// When the receiver stalls, the output register holds its item and s_tready
// drops until it is taken; s_tready stays high while the output register is
// empty or being emptied in the same cycle.
// Reset (rst_n, asynchronous): lines A=0 B=0 button released, no steps
// pending, both countdowns disarmed, registers at their default delays.
// APB: registers at 0x00 key start delay, 0x04 wheel start delay,
// 0x08 step interval, 0x0C release delay, 0x10 steps per detent; write
// only while no item is in flight.
module quadrature_encoder_signal_generator_core #(
    parameter int COUNT_WIDTH = qesg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qesg_pkg::IN_DATA_W-1:0]    s_tdata,  // [1:0] direction, [2] pressed
    input  logic [1:0]                        s_tuser,  // [1:0] cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qesg_pkg::OUT_DATA_W-1:0]   m_tdata,  // [0] phase_a, [1] phase_b, [2] button_n
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qesg_pkg::ADDR_W-1:0]       paddr,
    input  logic [qesg_pkg::DATA_W-1:0]       pwdata,
    output logic [qesg_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    qesg_pkg::cfg_t    cfg_reg;
    qesg_pkg::lines_t  lines_next;
    qesg_pkg::lines_t  out_reg;
    logic              m_valid_reg;
    logic              in_accept;
    logic              cfg_wr;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(qesg_pkg::OUT_DATA_W - 3){1'b0}}, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_start_delay   <= qesg_pkg::KEY_START_DELAY_RST;
            cfg_reg.wheel_start_delay <= qesg_pkg::WHEEL_START_DELAY_RST;
            cfg_reg.step_interval     <= qesg_pkg::STEP_INTERVAL_RST;
            cfg_reg.release_delay     <= qesg_pkg::RELEASE_DELAY_RST;
            cfg_reg.steps_per_detent  <= qesg_pkg::STEPS_PER_DETENT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                qesg_pkg::REG_KEY_START_DELAY:
                    cfg_reg.key_start_delay <= pwdata[qesg_pkg::DELAY_W-1:0];
                qesg_pkg::REG_WHEEL_START_DELAY:
                    cfg_reg.wheel_start_delay <= pwdata[qesg_pkg::DELAY_W-1:0];
                qesg_pkg::REG_STEP_INTERVAL:
                    cfg_reg.step_interval <= pwdata[qesg_pkg::DELAY_W-1:0];
                qesg_pkg::REG_RELEASE_DELAY:
                    cfg_reg.release_delay <= pwdata[qesg_pkg::DELAY_W-1:0];
                qesg_pkg::REG_STEPS_PER_DETENT:
                    cfg_reg.steps_per_detent <= pwdata[qesg_pkg::SPD_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            qesg_pkg::REG_KEY_START_DELAY:
                prdata = {{(qesg_pkg::DATA_W - qesg_pkg::DELAY_W){1'b0}},
                          cfg_reg.key_start_delay};
            qesg_pkg::REG_WHEEL_START_DELAY:
                prdata = {{(qesg_pkg::DATA_W - qesg_pkg::DELAY_W){1'b0}},
                          cfg_reg.wheel_start_delay};
            qesg_pkg::REG_STEP_INTERVAL:
                prdata = {{(qesg_pkg::DATA_W - qesg_pkg::DELAY_W){1'b0}},
                          cfg_reg.step_interval};
            qesg_pkg::REG_RELEASE_DELAY:
                prdata = {{(qesg_pkg::DATA_W - qesg_pkg::DELAY_W){1'b0}},
                          cfg_reg.release_delay};
            qesg_pkg::REG_STEPS_PER_DETENT:
                prdata = {{(qesg_pkg::DATA_W - qesg_pkg::SPD_W){1'b0}},
                          cfg_reg.steps_per_detent};
            default:
                prdata = '0;
        endcase
    end

    qesg_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (in_accept),
        .cmd        (qesg_pkg::cmd_t'(s_tuser)),
        .direction  (s_tdata[1:0]),
        .pressed    (s_tdata[2]),
        .cfg        (cfg_reg),
        .lines_next (lines_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_reg <= lines_next;
        end
    end

endmodule

// ===== rtl/qesg_checker.sv =====
module qesg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [1:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [qesg_pkg::OUT_DATA_W-1:0]   m_tdata
);

    // every accepted item leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted item");

    // a key push shows the button pressed in its own result
    a_push_presses: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == qesg_pkg::CMD_KEY_PUSH)
        |=> m_tvalid && !m_tdata[2])
        else $error("key push did not press the button");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[qesg_pkg::OUT_DATA_W-1:3] == '0))
        else $error("padding bits set");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

endmodule

bind quadrature_encoder_signal_generator_core qesg_checker u_qesg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
